FILE: rtl/pbfc_pkg.sv
package pbfc_pkg;

    localparam int GLYPH_COUNT      = 96;
    localparam int FIRST_CODE       = 32;
    localparam int GLYPH_W          = 5;
    localparam int GLYPH_H          = 7;
    localparam int ROM_ROW_BITS     = 80;
    localparam int GLYPHS_PER_ROW   = 16;
    localparam int ROM_WORDS        = 53;
    localparam int GLYPH_ROW_STRIDE = GLYPH_H * ROM_ROW_BITS;

    localparam int POS_BITS   = 12;
    localparam int GLYPH_BITS = $clog2(GLYPH_COUNT);
    localparam int CODE_BITS  = 8;
    localparam int XOUT_BITS  = 12;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 8;
    localparam int SPACING_BITS   = 4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHAR_SPACING   = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MONOSPACE_MODE = 8'd1;

    typedef logic [GLYPH_BITS-1:0] glyph_idx_t;

    typedef struct packed {
        logic [POS_BITS-1:0] pos;
        logic [2:0]          ncols;
        logic [2:0]          trow;
        logic                brow;
    } glyph_job_t;

    // bit clear means ink
    localparam logic [63:0] FONT_ROM [ROM_WORDS] = '{
        64'hffe77bfe7fbfff3f, 64'hfddd991ad73fdfff, 64'ha9d0d73fdfffffc2,
        64'hff3feffffdc2fddc, 64'hefe3f8e6fdff77ba, 64'h9dfefdfa8b787f3f,
        64'hfdfd8d1affffee7f, 64'h7fbfff3ff67f9ffe, 64'he739f7ffbfff7bfa,
        64'hcfffffff398661bc, 64'h7ce6d6bdbd9bdf76, 64'hd9dfb1addf76b77f,
        64'h2fabef76bee3bce6, 64'hf776ddffdffe36ec, 64'hcee3bce6f6edad0b,
        64'h7ce739ee73bcc639, 64'hffffffffffffff7f, 64'h0108c631cffffdff,
        64'h318e8b9d0a060c88, 64'h63099a4f2ce738c6, 64'h9c4f20e738ce3182,
        64'h202420ce40026201, 64'h38c6319e6095984f, 64'h8191619c9a4b2c67,
        64'h8b9c0a660c8f0108, 64'hffffffffffffffff, 64'hce738808c230ffff,
        64'h89b6318cfef3dcc1, 64'hb18cfd77deddd573, 64'hfbb7beeebb5549bc,
        64'hbef77b5549bbc190, 64'h7506c9b6319cfff7, 64'he3b8b23cfff7befb,
        64'hfcfffff77ec36eae, 64'h07f37cffffffffff, 64'hbeef7ffffffffff3,
        64'hfdccf37cfb37ffff, 64'h6d7b7aefce69beff, 64'h621fb555baef7db7,
        64'hb555bcef79b4611f, 64'hbaef75cf7d6b5adf, 64'h75f7730cc33fb555,
        64'hffffffffcd559aef, 64'hfffffffffff7ffcf, 64'h07f3b9ffffffffff,
        64'hbdc2d673abbcd738, 64'hd673ab1f66d667f7, 64'h6bbcf6d66377bdde,
        64'hf63862afbee73955, 64'h65b7bdfb76046bbb, 64'hbdc396aee77cf6fe,
        64'hfffffffffefe67f7, 64'h0000000007f3b9ff
    };

    // {left margin[1:0], right margin[1:0], top trim[2:0], bottom trim}
    localparam logic [7:0] GLYPH_TRIM [GLYPH_COUNT] = '{
        8'h55, 8'h60, 8'h53, 8'h03, 8'h50, 8'h03, 8'h00, 8'ha3,
        8'h60, 8'h90, 8'h11, 8'h55, 8'h68, 8'h57, 8'h69, 8'h20,
        8'h11, 8'h51, 8'h51, 8'h51, 8'h11, 8'h11, 8'h11, 8'h11,
        8'h11, 8'h11, 8'h63, 8'h62, 8'h53, 8'h55, 8'h53, 8'h10,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h11, 8'h01, 8'h11, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h11, 8'h60, 8'h50, 8'h60, 8'h01, 8'h0c,
        8'h81, 8'h13, 8'h13, 8'h13, 8'h13, 8'h13, 8'h53, 8'h12,
        8'h53, 8'ha1, 8'h60, 8'h51, 8'h61, 8'h03, 8'h53, 8'h13,
        8'h12, 8'h12, 8'h53, 8'h13, 8'h53, 8'h53, 8'h03, 8'h03,
        8'h13, 8'h13, 8'h13, 8'h50, 8'ha0, 8'h50, 8'h05, 8'h00
    };

    function automatic logic rom_ink(logic [POS_BITS-1:0] bitpos);
        return !FONT_ROM[bitpos[11:6]][bitpos[5:0]];
    endfunction

endpackage

FILE: rtl/pbfc_front.sv
module pbfc_front #(
    parameter int CURSOR_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pbfc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pbfc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [pbfc_pkg::CODE_BITS-1:0]       char_code,
    input  logic                                 first_char,
    input  logic                                 queue_full,
    output logic                                 push,
    output logic [CURSOR_BITS-1:0]               push_start,
    output pbfc_pkg::glyph_job_t                 push_job
);

    localparam int SW = CURSOR_BITS + 1;
    localparam logic [CURSOR_BITS-1:0] CUR_MAX = '1;

    logic [CURSOR_BITS-1:0]              cursor_reg, cursor_next;
    logic [pbfc_pkg::SPACING_BITS-1:0]   spacing_reg, spacing_next;
    logic                                mono_reg, mono_next;

    logic                                in_font;
    pbfc_pkg::glyph_idx_t                glyph;
    logic [7:0]                          trim;
    logic [1:0]                          lmar, rmar, first_col;
    logic [2:0]                          ncols;
    logic [pbfc_pkg::POS_BITS-1:0]       base;
    logic [SW-1:0]                       sum_start, sum_end;
    logic [CURSOR_BITS-1:0]              start;

    assign cfg_ready = 1'b1;
    assign in_ready  = !queue_full;
    assign push      = in_valid && in_ready;

    always_comb
    begin
        in_font = !char_code[7] && (char_code[6:5] != 2'b00);
        glyph = in_font ? pbfc_pkg::GLYPH_BITS'(char_code - 8'(pbfc_pkg::FIRST_CODE))
                        : pbfc_pkg::GLYPH_BITS'(pbfc_pkg::GLYPH_COUNT - 1);
        trim  = pbfc_pkg::GLYPH_TRIM[glyph];
        lmar  = trim[7:6];
        rmar  = trim[5:4];
        first_col = mono_reg ? 2'd0 : lmar;
        ncols = mono_reg ? 3'(pbfc_pkg::GLYPH_W)
                         : 3'(3'(pbfc_pkg::GLYPH_W) - {1'b0, lmar} - {1'b0, rmar});
        base  = pbfc_pkg::POS_BITS'(glyph[6:4]) * pbfc_pkg::POS_BITS'(pbfc_pkg::GLYPH_ROW_STRIDE)
              + pbfc_pkg::POS_BITS'(glyph[3:0]) * pbfc_pkg::POS_BITS'(pbfc_pkg::GLYPH_W);

        sum_start = {1'b0, cursor_reg} + SW'(spacing_reg);
        if (first_char)
        begin
            start = '0;
        end
        else
        begin
            start = sum_start[CURSOR_BITS] ? CUR_MAX : sum_start[CURSOR_BITS-1:0];
        end
        sum_end = {1'b0, start} + SW'(ncols);

        push_start     = start;
        push_job.pos   = base + pbfc_pkg::POS_BITS'(first_col);
        push_job.ncols = ncols;
        push_job.trow  = trim[3:1];
        push_job.brow  = trim[0];
    end

    always_comb
    begin
        cursor_next  = cursor_reg;
        spacing_next = spacing_reg;
        mono_next    = mono_reg;
        if (push)
        begin
            cursor_next = sum_end[CURSOR_BITS] ? CUR_MAX : sum_end[CURSOR_BITS-1:0];
        end
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == pbfc_pkg::CFG_CHAR_SPACING)
            begin
                spacing_next = cfg_data[pbfc_pkg::SPACING_BITS-1:0];
            end
            else if (cfg_index == pbfc_pkg::CFG_MONOSPACE_MODE)
            begin
                mono_next = cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg  <= '0;
            spacing_reg <= pbfc_pkg::SPACING_BITS'(1);
            mono_reg    <= 1'b0;
        end
        else
        begin
            cursor_reg  <= cursor_next;
            spacing_reg <= spacing_next;
            mono_reg    <= mono_next;
        end
    end

    // cursor only moves backward on a line start
    a_cursor_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        push && !first_char |=> cursor_reg >= $past(cursor_reg))
        else $error("line cursor moved backward without a line start");

endmodule

FILE: rtl/pbfc_fifo.sv
module pbfc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

FILE: rtl/pbfc_back.sv
module pbfc_back #(
    parameter int CURSOR_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              job_valid,
    input  logic [CURSOR_BITS-1:0]            job_start,
    input  pbfc_pkg::glyph_job_t              job,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pbfc_pkg::XOUT_BITS-1:0]    column_x,
    output logic [pbfc_pkg::GLYPH_H-1:0]      column_pixels,
    output logic                              last_column
);

    localparam logic [CURSOR_BITS-1:0] CUR_MAX = '1;

    logic                           busy_reg, busy_next;
    pbfc_pkg::glyph_job_t           job_reg, job_next;
    logic [2:0]                     col_reg, col_next;
    logic [pbfc_pkg::POS_BITS-1:0]  pos_reg, pos_next;
    logic [CURSOR_BITS-1:0]         x_reg, x_next;

    logic                           out_valid_reg, out_valid_next;
    logic [CURSOR_BITS-1:0]         out_x_reg;
    logic [pbfc_pkg::GLYPH_H-1:0]   out_pix_reg;
    logic                           out_last_reg;

    logic                           can_load, step, is_last;
    logic [pbfc_pkg::GLYPH_H-1:0]   pixels;
    logic [CURSOR_BITS+pbfc_pkg::XOUT_BITS-1:0] x_ext;

    assign can_load = !out_valid_reg || out_ready;
    assign step     = busy_reg && can_load;
    assign is_last  = (col_reg == job_reg.ncols - 3'd1);
    assign pop      = job_valid && (!busy_reg || (step && is_last));

    // row r is inked when the rom bit is clear and r lies inside the trim
    always_comb
    begin
        for (int r = 0; r < pbfc_pkg::GLYPH_H; r++)
        begin
            pixels[r] = pbfc_pkg::rom_ink(pos_reg
                            + pbfc_pkg::POS_BITS'(r * pbfc_pkg::ROM_ROW_BITS))
                        && (3'(r) >= job_reg.trow)
                        && ((4'(r) + 4'(job_reg.brow)) < 4'(pbfc_pkg::GLYPH_H));
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        job_next  = job_reg;
        col_next  = col_reg;
        pos_next  = pos_reg;
        x_next    = x_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            job_next  = job;
            col_next  = '0;
            pos_next  = job.pos;
            x_next    = job_start;
        end
        else if (step)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            col_next = col_reg + 3'd1;
            pos_next = pos_reg + pbfc_pkg::POS_BITS'(1);
            x_next   = (x_reg == CUR_MAX) ? x_reg : x_reg + CURSOR_BITS'(1);
        end
    end

    always_comb
    begin
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        col_reg <= col_next;
        pos_reg <= pos_next;
        x_reg   <= x_next;
        if (step)
        begin
            out_x_reg    <= x_reg;
            out_pix_reg  <= pixels;
            out_last_reg <= is_last;
        end
    end

    assign x_ext         = {{pbfc_pkg::XOUT_BITS{1'b0}}, out_x_reg};
    assign out_valid     = out_valid_reg;
    assign column_x      = x_ext[pbfc_pkg::XOUT_BITS-1:0];
    assign column_pixels = out_pix_reg;
    assign last_column   = out_last_reg;

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> col_reg < job_reg.ncols)
        else $error("column counter ran past the glyph width");

    // a new glyph is taken only once the previous one has emitted its last column
    a_pop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop && busy_reg |-> step && is_last)
        else $error("glyph dropped before its last column");

endmodule

FILE: rtl/proportional_bitmap_font_columns_unit.sv
// path: accepted char beat -> queue -> job regs -> output regs -> first column
// throughput: one column per cycle from the back end rom read while out_ready
// holds; a character has 1 to 5 columns; characters queue two deep in between
// reset: async active low; cursor 0, char_spacing 1, monospace_mode 0, queue
// empty, no output pending; no clearing pass
module proportional_bitmap_font_columns_unit #(
    parameter int CURSOR_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pbfc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pbfc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [pbfc_pkg::CODE_BITS-1:0]       char_code,
    input  logic                                 first_char,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [pbfc_pkg::XOUT_BITS-1:0]       column_x,
    output logic [pbfc_pkg::GLYPH_H-1:0]         column_pixels,
    output logic                                 last_column
);

    localparam int QUEUE_DEPTH = 2;
    localparam int JOB_BITS    = $bits(pbfc_pkg::glyph_job_t);
    localparam int ENTRY_BITS  = CURSOR_BITS + JOB_BITS;

    logic                       push, pop, queue_full, queue_empty;
    logic [CURSOR_BITS-1:0]     push_start;
    pbfc_pkg::glyph_job_t       push_job, pop_job;
    logic [ENTRY_BITS-1:0]      pop_entry;

    pbfc_front #(
        .CURSOR_BITS (CURSOR_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .first_char (first_char),
        .queue_full (queue_full),
        .push       (push),
        .push_start (push_start),
        .push_job   (push_job)
    );

    pbfc_fifo #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_start, push_job}),
        .pop       (pop),
        .pop_data  (pop_entry),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    assign pop_job = pop_entry[JOB_BITS-1:0];

    pbfc_back #(
        .CURSOR_BITS (CURSOR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (!queue_empty),
        .job_start     (pop_entry[ENTRY_BITS-1:JOB_BITS]),
        .job           (pop_job),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .column_x      (column_x),
        .column_pixels (column_pixels),
        .last_column   (last_column)
    );

endmodule
